// ===== hw/rtl/stack_vm_branch_unit_macros.svh =====
// Assertion helpers used by the checker file of the branch unit.
// Every property is sampled on the rising edge of clock.
`ifndef STACK_VM_BRANCH_UNIT_MACROS_SVH
`define STACK_VM_BRANCH_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define SBU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbu: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define SBU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbu: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SBU_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sbu: reset check failed");

`endif

// ===== hw/rtl/sbu_pkg.sv =====
`default_nettype none

package sbu_pkg;

   typedef enum logic [3:0] {
      ACT_JMP  = 4'd0,
      ACT_JZ   = 4'd1,
      ACT_JNZ  = 4'd2,
      ACT_JG   = 4'd3,
      ACT_JL   = 4'd4,
      ACT_JGE  = 4'd5,
      ACT_JLE  = 4'd6,
      ACT_CALL = 4'd7,
      ACT_RET  = 4'd8,
      ACT_PUSH = 4'd9
   } act_type;

   typedef enum logic [1:0] {
      FLT_NONE  = 2'd0,
      FLT_OOB   = 2'd1,
      FLT_UNDER = 2'd2,
      FLT_OVER  = 2'd3
   } fault_type;

   // Distance from a call to its return point.
   localparam logic [63:0] RET_STEP = 64'd3;

   typedef struct packed {
      logic [3:0]         action;
      logic [31:0]        instr_addr;
      logic signed [15:0] offset;
      logic [63:0]        push_value;
   } req_type;

   typedef struct packed {
      logic [31:0] next_addr;
      logic        taken;
      logic [1:0]  fault;
      logic [6:0]  depth;
   } rsp_type;

   // Stack update requested by the execute logic for one beat.
   typedef struct packed {
      logic        pop_one;
      logic        pop_two;
      logic        push;
      logic [63:0] data;
   } stk_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sbu_ram.sv =====
`default_nettype none

module sbu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sbu_stack.sv =====
`default_nettype none

module sbu_stack #(
   parameter int STACK_ENTRIES = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sbu_pkg::stk_cmd_type                 cmd,
   output logic [$clog2(STACK_ENTRIES+1)-1:0]        count,
   output logic [63:0]                               top,
   output logic [63:0]                               second
);

   localparam int CNT_W = $clog2(STACK_ENTRIES + 1);
   localparam int IDX_W = $clog2(STACK_ENTRIES);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] cnt_m2;
   logic [IDX_W-1:0] rd_addr_a;
   logic [IDX_W-1:0] rd_addr_b;
   logic [63:0]      rd_data_a;
   logic [63:0]      rd_data_b;
   logic             byp_ff;
   logic [63:0]      byp_data_ff;

   always_comb begin
      count_in = count_ff + CNT_W'(cmd.push) - CNT_W'(cmd.pop_one)
               - (cmd.pop_two ? CNT_W'(2) : '0);
      cnt_m1   = count_in - CNT_W'(1);
      cnt_m2   = count_in - CNT_W'(2);
      // Prefetch the two entries on top of the stack as it will stand.
      rd_addr_a = (count_in >= CNT_W'(1)) ? cnt_m1[IDX_W-1:0] : '0;
      rd_addr_b = (count_in >= CNT_W'(2)) ? cnt_m2[IDX_W-1:0] : '0;
   end

   sbu_ram #(
      .WIDTH (64),
      .DEPTH (STACK_ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (cmd.push),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (cmd.data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         byp_ff   <= cmd.push;
      end
      if (cmd.push) begin
         byp_data_ff <= cmd.data;
      end
   end

   // A push writes the slot that is read for the new top in the same cycle,
   // so the RAM returns stale data there and the pushed value is forwarded.
   assign count  = count_ff;
   assign top    = byp_ff ? byp_data_ff : rd_data_a;
   assign second = rd_data_b;

endmodule

`default_nettype wire

// ===== hw/rtl/sbu_exec.sv =====
`default_nettype none

module sbu_exec #(
   parameter int STACK_ENTRIES = 64,
   parameter int ADDR_BITS     = 32
) (
   input  wire sbu_pkg::req_type                   req,
   input  wire logic [$clog2(STACK_ENTRIES+1)-1:0] count,
   input  wire logic [63:0]                        top,
   input  wire logic [63:0]                        second,
   output sbu_pkg::rsp_type                        rsp,
   output sbu_pkg::stk_cmd_type                    cmd
);

   localparam int               CNT_W     = $clog2(STACK_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STACK_ENTRIES);
   localparam logic [63:0]      ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

   logic [63:0]      ip;
   logic [63:0]      off_ext;
   logic [33:0]      low_sum;
   logic             oob;
   logic [63:0]      tgt;
   logic [63:0]      ret_addr;
   logic [63:0]      next;
   logic             cond;
   logic             taken;
   sbu_pkg::fault_type fault;
   logic             ge1;
   logic             ge2;
   logic             full;
   logic [CNT_W-1:0] cnt_after;

   always_comb begin
      ip       = {32'd0, req.instr_addr} & ADDR_MASK;
      off_ext  = {{48{req.offset[15]}}, req.offset};
      // Sign of the untruncated target tells a jump below address zero.
      low_sum  = {2'b00, ip[31:0]} + {{18{req.offset[15]}}, req.offset};
      oob      = low_sum[33];
      tgt      = (ip + off_ext) & ADDR_MASK;
      ret_addr = (ip + sbu_pkg::RET_STEP) & ADDR_MASK;

      ge1  = (count != '0);
      ge2  = (count >= CNT_W'(2));
      full = (count >= FULL_CNT);

      next  = ip;
      cond  = 1'b0;
      taken = 1'b0;
      fault = sbu_pkg::FLT_NONE;
      cmd   = '0;

      unique case (sbu_pkg::act_type'(req.action))
         sbu_pkg::ACT_JMP: begin
            cond = 1'b1;
         end
         sbu_pkg::ACT_JZ, sbu_pkg::ACT_JNZ: begin
            if (!ge1) begin
               fault = sbu_pkg::FLT_UNDER;
            end else begin
               cmd.pop_one = 1'b1;
               cond = (req.action == sbu_pkg::ACT_JZ) ? (top == '0) : (top != '0);
            end
         end
         sbu_pkg::ACT_JG, sbu_pkg::ACT_JL, sbu_pkg::ACT_JGE, sbu_pkg::ACT_JLE: begin
            if (!ge2) begin
               fault = sbu_pkg::FLT_UNDER;
            end else begin
               cmd.pop_two = 1'b1;
               case (sbu_pkg::act_type'(req.action))
                  sbu_pkg::ACT_JG:  cond = second > top;
                  sbu_pkg::ACT_JL:  cond = second < top;
                  sbu_pkg::ACT_JGE: cond = second >= top;
                  default:          cond = second <= top;
               endcase
            end
         end
         sbu_pkg::ACT_CALL: begin
            if (full) begin
               fault = sbu_pkg::FLT_OVER;
            end else if (oob) begin
               fault = sbu_pkg::FLT_OOB;
            end else begin
               cmd.push = 1'b1;
               cmd.data = ret_addr;
               next     = tgt;
               taken    = 1'b1;
            end
         end
         sbu_pkg::ACT_RET: begin
            if (!ge1) begin
               fault = sbu_pkg::FLT_UNDER;
            end else begin
               cmd.pop_one = 1'b1;
               next  = top & ADDR_MASK;
               taken = 1'b1;
            end
         end
         sbu_pkg::ACT_PUSH: begin
            if (full) begin
               fault = sbu_pkg::FLT_OVER;
            end else begin
               cmd.push = 1'b1;
               cmd.data = req.push_value;
            end
         end
         default: begin
         end
      endcase

      if (cond) begin
         if (oob) begin
            fault = sbu_pkg::FLT_OOB;
         end else begin
            next  = tgt;
            taken = 1'b1;
         end
      end

      cnt_after = count + CNT_W'(cmd.push) - CNT_W'(cmd.pop_one)
                - (cmd.pop_two ? CNT_W'(2) : '0);

      rsp.next_addr = next[31:0];
      rsp.taken     = taken;
      rsp.fault     = fault;
      rsp.depth     = 7'(cnt_after);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stack_vm_branch_unit.sv =====
// Each beat passes the input register, then the result register. Throughput:
// one beat per cycle while rsp_ready is high, set by the stack count register
// and the two-port stack RAM, whose prefetch of the top two entries closes
// each cycle. Reset (synchronous, active high) empties the stack and both beat
// registers; stack RAM contents are not cleared and are only read once written.
`default_nettype none

module stack_vm_branch_unit #(
   parameter int STACK_ENTRIES = 64,
   parameter int ADDR_BITS     = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sbu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sbu_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(STACK_ENTRIES + 1);

   // Input register: holds the beat that executes in the current cycle.
   sbu_pkg::req_type     req_ff;
   logic                 req_vld_ff;
   // Result register: holds the finished beat until the consumer takes it.
   sbu_pkg::rsp_type     rsp_ff;
   logic                 rsp_vld_ff;

   sbu_pkg::rsp_type     rsp_in;
   sbu_pkg::stk_cmd_type cmd;
   sbu_pkg::stk_cmd_type cmd_fire;
   logic                 fire;
   logic [CNT_W-1:0]     count;
   logic [63:0]          top;
   logic [63:0]          second;

   // The held beat executes whenever the result register is free or is being
   // drained in this same cycle. The input side refills behind it, so a steady
   // stream moves one beat per clock with no bubble while rsp_ready stays high.
   assign fire      = req_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~req_vld_ff | fire;

   // The stack only changes when the beat actually retires into the result
   // register; a stalled beat re-evaluates against unchanged stack state.
   always_comb begin
      cmd_fire         = cmd;
      cmd_fire.pop_one = cmd.pop_one & fire;
      cmd_fire.pop_two = cmd.pop_two & fire;
      cmd_fire.push    = cmd.push & fire;
   end

   sbu_exec #(
      .STACK_ENTRIES (STACK_ENTRIES),
      .ADDR_BITS     (ADDR_BITS)
   ) u_exec (
      .req    (req_ff),
      .count  (count),
      .top    (top),
      .second (second),
      .rsp    (rsp_in),
      .cmd    (cmd)
   );

   // The stack keeps its count in a register and prefetches the top two
   // entries for whatever count it is about to hold, so the next beat finds
   // its operands ready.
   sbu_stack #(
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_fire),
      .count  (count),
      .top    (top),
      .second (second)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (fire) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sbu_checker.sv =====
`default_nettype none

`include "stack_vm_branch_unit_macros.svh"

module sbu_checker #(
   parameter int STACK_ENTRIES = 64
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire sbu_pkg::rsp_type rsp_data
);

   // A result beat that is not taken stays and keeps its payload.
   `SBU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A redirect never comes with a fault.
   `SBU_ASSERT_NOW(a_taken_clean, rsp_valid && rsp_data.taken, rsp_data.fault == sbu_pkg::FLT_NONE)

   // The reported depth never exceeds the stack size.
   `SBU_ASSERT_NOW(a_depth_bound, rsp_valid, 32'(rsp_data.depth) <= 32'(STACK_ENTRIES))

   // Reset leaves no result pending and the request side open.
   `SBU_ASSERT_RST(a_reset_idle, reset, !rsp_valid && req_ready)

endmodule

bind stack_vm_branch_unit sbu_checker #(
   .STACK_ENTRIES (STACK_ENTRIES)
) u_sbu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/tb_stack_vm_branch_unit.sv =====
`default_nettype none

// Self-checking bench for the branch and call unit of the stack machine.
// Each request beat is run through a behavioral model of the unit when it is
// accepted, and the outcome it predicts is queued. Every response beat is then
// compared field by field against the oldest queued outcome.
module tb_stack_vm_branch_unit;

   localparam int STACK_DEPTH_MAX = 64;
   localparam int ADDR_WIDTH      = 32;
   localparam int REPORT_LIMIT    = 10;
   localparam int DRAIN_GUARD     = 100000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int HOLD_OFF_CYCLES = 60;

   // Action codes the unit does not define; they must behave as no-ops.
   localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
   localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

   // All bench-driven signals start at known values before the first edge.
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   sbu_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   sbu_pkg::rsp_type rsp_data;

   stack_vm_branch_unit #(
      .STACK_ENTRIES(STACK_DEPTH_MAX),
      .ADDR_BITS    (ADDR_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Model state: a private copy of the operand stack and its depth.
   logic [63:0] stack_mem [STACK_DEPTH_MAX];
   int          stack_depth;

   // Outcomes predicted for accepted requests, oldest first.
   sbu_pkg::rsp_type outcome_queue [$];

   int          mismatch_count = 0;
   bit          sender_gaps_on = 1'b1;
   bit          rsp_stalls_on  = 1'b1;
   int          hold_req       = 0;
   int          stall_left     = 0;
   logic [63:0] last_push      = '0;

   // Relative jump target. A backward jump that would go below address zero
   // is refused; forward jumps simply wrap at the address width.
   function automatic logic jump_target(input logic [31:0] ip,
                                        input logic signed [15:0] off,
                                        output logic [31:0] dst);
      logic [31:0] mag;
      dst = ip;
      if (off < 0) begin
         mag = 32'(-int'(off));
         if (mag > ip) return 1'b0;
         dst = ip - mag;
      end else begin
         dst = ip + 32'(off);
      end
      return 1'b1;
   endfunction

   // Predicts the response to one request and advances the model stack.
   function automatic sbu_pkg::rsp_type branch_outcome(input sbu_pkg::req_type beat);
      sbu_pkg::rsp_type   res;
      sbu_pkg::fault_type flt;
      logic               cond;
      logic [31:0]        dst;
      logic [63:0]        lhs;
      logic [63:0]        rhs;
      res.next_addr = beat.instr_addr;
      res.taken     = 1'b0;
      flt           = sbu_pkg::FLT_NONE;
      cond          = 1'b0;
      dst           = '0;
      case (beat.action)
         sbu_pkg::ACT_JMP: cond = 1'b1;
         sbu_pkg::ACT_JZ, sbu_pkg::ACT_JNZ: begin
            if (stack_depth < 1) begin
               flt = sbu_pkg::FLT_UNDER;
            end else begin
               stack_depth--;
               rhs  = stack_mem[stack_depth];
               cond = (beat.action == sbu_pkg::ACT_JZ) ? (rhs == '0) : (rhs != '0);
            end
         end
         sbu_pkg::ACT_JG, sbu_pkg::ACT_JL, sbu_pkg::ACT_JGE, sbu_pkg::ACT_JLE: begin
            // The first value popped is the right-hand operand.
            if (stack_depth < 2) begin
               flt = sbu_pkg::FLT_UNDER;
            end else begin
               rhs = stack_mem[stack_depth - 1];
               lhs = stack_mem[stack_depth - 2];
               stack_depth -= 2;
               case (beat.action)
                  sbu_pkg::ACT_JG:  cond = lhs > rhs;
                  sbu_pkg::ACT_JL:  cond = lhs < rhs;
                  sbu_pkg::ACT_JGE: cond = lhs >= rhs;
                  default:          cond = lhs <= rhs;
               endcase
            end
         end
         sbu_pkg::ACT_CALL: begin
            // Overflow wins over a bad target; a refused call pushes nothing.
            if (stack_depth >= STACK_DEPTH_MAX) begin
               flt = sbu_pkg::FLT_OVER;
            end else if (!jump_target(beat.instr_addr, beat.offset, dst)) begin
               flt = sbu_pkg::FLT_OOB;
            end else begin
               stack_mem[stack_depth] = 64'(32'(beat.instr_addr + sbu_pkg::RET_STEP));
               stack_depth++;
               res.next_addr = dst;
               res.taken     = 1'b1;
            end
         end
         sbu_pkg::ACT_RET: begin
            if (stack_depth < 1) begin
               flt = sbu_pkg::FLT_UNDER;
            end else begin
               stack_depth--;
               res.next_addr = stack_mem[stack_depth][31:0];
               res.taken     = 1'b1;
            end
         end
         sbu_pkg::ACT_PUSH: begin
            if (stack_depth >= STACK_DEPTH_MAX) begin
               flt = sbu_pkg::FLT_OVER;
            end else begin
               stack_mem[stack_depth] = beat.push_value;
               stack_depth++;
            end
         end
         default: ;
      endcase
      // Conditional and plain jumps keep their pops even if the target faults.
      if (cond && flt == sbu_pkg::FLT_NONE) begin
         if (jump_target(beat.instr_addr, beat.offset, dst)) begin
            res.next_addr = dst;
            res.taken     = 1'b1;
         end else begin
            flt = sbu_pkg::FLT_OOB;
         end
      end
      res.fault = flt;
      res.depth = 7'(stack_depth);
      return res;
   endfunction

   function automatic sbu_pkg::req_type make_beat(input logic [3:0] action,
                                                  input logic [31:0] ip,
                                                  input int off,
                                                  input logic [63:0] value);
      sbu_pkg::req_type beat;
      beat.action     = action;
      beat.instr_addr = ip;
      beat.offset     = 16'(off);
      beat.push_value = value;
      return beat;
   endfunction

   // Idle length: mostly none, often short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] random_addr();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return $urandom;
      if (roll < 72) return $urandom_range(0, 40000);
      if (roll < 90) return 32'hFFFF_0000 | 32'($urandom_range(0, 16'hFFFF));
      return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
   endfunction

   function automatic int random_offset();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return int'($signed(16'($urandom)));
      case ($urandom_range(0, 4))
         0:       return 32767;
         1:       return -32768;
         2:       return 0;
         default: return int'($urandom_range(0, 20)) - 10;
      endcase
   endfunction

   // Small values and repeats make zero tests and equal comparisons common;
   // address-sized values give returns that land somewhere plausible.
   function automatic logic [63:0] random_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)      last_push = {$urandom, $urandom};
      else if (roll < 65) last_push = 64'($urandom_range(0, 3));
      else if (roll < 80) last_push = last_push;
      else if (roll < 93) last_push = 64'($urandom);
      else                last_push = ($urandom_range(0, 1) != 0) ? '1 : '0;
      return last_push;
   endfunction

   // Random request; push_pct steers the stack toward full or toward empty.
   function automatic sbu_pkg::req_type make_random_beat(input int push_pct);
      sbu_pkg::req_type beat;
      int               roll;
      beat = make_beat(sbu_pkg::ACT_PUSH, random_addr(), random_offset(), random_value());
      if ($urandom_range(0, 99) >= push_pct) begin
         roll = $urandom_range(0, 99);
         if (roll < 10)      beat.action = sbu_pkg::ACT_JMP;
         else if (roll < 25) beat.action = sbu_pkg::ACT_JZ + 4'($urandom_range(0, 1));
         else if (roll < 55) beat.action = sbu_pkg::ACT_JG + 4'($urandom_range(0, 3));
         else if (roll < 70) beat.action = sbu_pkg::ACT_CALL;
         else if (roll < 95) beat.action = sbu_pkg::ACT_RET;
         else                beat.action = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      return beat;
   endfunction

   // Offers one beat and holds it until accepted. Valid is only dropped when
   // a gap follows, so back-to-back beats never lower and raise it in one step.
   task automatic send_beat(input sbu_pkg::req_type beat);
      int gap;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome_queue.push_back(branch_outcome(beat));
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (outcome_queue.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic note_mismatch(input string what,
                                input sbu_pkg::rsp_type want,
                                input sbu_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch: %s", what);
         $display("   expected next_addr=%h taken=%b fault=%0d depth=%0d",
                  want.next_addr, want.taken, want.fault, want.depth);
         $display("   actual   next_addr=%h taken=%b fault=%0d depth=%0d",
                  got.next_addr, got.taken, got.fault, got.depth);
      end
   endtask

   // The response side owns rsp_ready. A hold-off request from a test loads the
   // stall countdown that keeps ready low; otherwise stalls are drawn at random.
   always @(posedge clock) begin
      if (hold_req > 0) begin
         stall_left = hold_req;
         hold_req   = 0;
      end else if (stall_left == 0 && rsp_stalls_on) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every response beat taken by the bench is matched against the oldest
   // outstanding prediction.
   always @(posedge clock) begin : check_outcomes
      sbu_pkg::rsp_type want;
      string            bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_queue.size() == 0) begin
            note_mismatch("response beat with no request outstanding", '0, rsp_data);
         end else begin
            want = outcome_queue.pop_front();
            bad  = "";
            if (rsp_data.next_addr !== want.next_addr) bad = {bad, " next_addr"};
            if (rsp_data.taken !== want.taken)         bad = {bad, " taken"};
            if (rsp_data.fault !== want.fault)         bad = {bad, " fault"};
            if (rsp_data.depth !== want.depth)         bad = {bad, " depth"};
            if (bad != "") note_mismatch({"wrong", bad}, want, rsp_data);
         end
      end
   end

   task automatic apply_reset();
      int idx;
      for (idx = 0; idx < STACK_DEPTH_MAX; idx++) stack_mem[idx] = '0;
      stack_depth = 0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   endtask

   // Jump targets at both ends of the address space and of the offset range.
   task automatic test_jump_bounds();
      send_beat(make_beat(sbu_pkg::ACT_JMP, 32'h0000_0000, -1, '0));
      send_beat(make_beat(sbu_pkg::ACT_JMP, 32'hFFFF_FFFF, 1, '1));
      send_beat(make_beat(sbu_pkg::ACT_JMP, 32'h0000_8000, -32768, '0));
      send_beat(make_beat(sbu_pkg::ACT_JMP, 32'h0000_7FFF, -32768, '0));
      send_beat(make_beat(sbu_pkg::ACT_JMP, 32'h0000_03E8, 32767, '0));
   endtask

   // Pops on empty or short stacks, a taken test whose target is out of
   // bounds, and unsigned comparisons including equal operands.
   task automatic test_conditions();
      send_beat(make_beat(sbu_pkg::ACT_JZ, 32'h0000_0040, 4, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0044, 0, 64'd0));
      send_beat(make_beat(sbu_pkg::ACT_JZ, 32'h0000_000A, -11, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0050, 0, '1));
      send_beat(make_beat(sbu_pkg::ACT_JG, 32'h0000_0054, 8, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0058, 0, 64'd1));
      send_beat(make_beat(sbu_pkg::ACT_JL, 32'h0000_005C, 8, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0060, 0, 64'd7));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0064, 0, 64'd7));
      send_beat(make_beat(sbu_pkg::ACT_JGE, 32'h0000_0068, -16, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_006C, 0, 64'd3));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0070, 0, 64'd9));
      send_beat(make_beat(sbu_pkg::ACT_JLE, 32'h0000_0074, 100, '0));
   endtask

   // A call whose return address wraps, a refused call, a return through a
   // value wider than an address, a return on an empty stack, and an
   // undefined action code.
   task automatic test_call_return();
      send_beat(make_beat(sbu_pkg::ACT_CALL, 32'hFFFF_FFFE, 16, '0));
      send_beat(make_beat(sbu_pkg::ACT_JNZ, 32'h0000_000E, 2, '0));
      send_beat(make_beat(sbu_pkg::ACT_CALL, 32'h0000_0005, -6, '0));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, 32'h0000_0200, 0, 64'hFFFF_0000_1234_5678));
      send_beat(make_beat(sbu_pkg::ACT_RET, 32'h0000_0204, 0, '0));
      send_beat(make_beat(sbu_pkg::ACT_RET, 32'h0000_0208, 0, '0));
      send_beat(make_beat(ACT_UNUSED_HI, 32'hDEAD_BEEF, -1, '1));
   endtask

   // Fill the stack to the top, try to grow it further, then pop it empty
   // and try to pop it further.
   task automatic test_stack_full();
      sbu_pkg::req_type beat;
      while (stack_depth < STACK_DEPTH_MAX)
         send_beat(make_beat(sbu_pkg::ACT_PUSH, random_addr(), random_offset(),
                             random_value()));
      send_beat(make_beat(sbu_pkg::ACT_PUSH, random_addr(), random_offset(), random_value()));
      send_beat(make_beat(sbu_pkg::ACT_CALL, 32'h0000_0000, -5, '0));
      send_beat(make_beat(sbu_pkg::ACT_CALL, random_addr(), random_offset(), random_value()));
      while (stack_depth > 0) begin
         beat = make_random_beat(0);
         if (beat.action == sbu_pkg::ACT_CALL) beat.action = sbu_pkg::ACT_RET;
         send_beat(beat);
      end
      send_beat(make_beat(sbu_pkg::ACT_JGE, random_addr(), random_offset(), '0));
      send_beat(make_beat(sbu_pkg::ACT_RET, random_addr(), random_offset(), '0));
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming back to back, so the unit fills and must stall its input.
   task automatic test_backpressure();
      int idx;
      sender_gaps_on = 1'b0;
      hold_req = HOLD_OFF_CYCLES;
      for (idx = 0; idx < 30; idx++) send_beat(make_random_beat(50));
      sender_gaps_on = 1'b1;
      wait_for_drain();
   endtask

   // The request side stops until every outstanding response has arrived,
   // then resumes.
   task automatic test_drain_pause();
      int idx;
      for (idx = 0; idx < 40; idx++) send_beat(make_random_beat(45));
      wait_for_drain();
      for (idx = 0; idx < 40; idx++) send_beat(make_random_beat(45));
   endtask

   // Long random run in segments that push the stack toward full and toward
   // empty in turn. Some segments run with no idling on either side.
   task automatic test_random_walk(input int beats);
      int sent;
      int seg_len;
      int push_pct;
      bit fill_turn;
      sent      = 0;
      fill_turn = 1'b1;
      while (sent < beats) begin
         seg_len        = $urandom_range(20, 80);
         push_pct       = fill_turn ? 65 : 20;
         fill_turn      = !fill_turn;
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on  = sender_gaps_on;
         repeat (seg_len) begin
            send_beat(make_random_beat(push_pct));
            sent++;
         end
      end
      sender_gaps_on = 1'b1;
      rsp_stalls_on  = 1'b1;
   endtask

   initial begin
      apply_reset();
      test_jump_bounds();
      test_conditions();
      test_call_return();
      test_stack_full();
      test_backpressure();
      test_drain_pause();
      test_random_walk(520);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_queue.size() != 0) begin
         mismatch_count++;
         $display("error: %0d responses never arrived", outcome_queue.size());
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Backstop in case the unit stops answering.
   initial begin
      #(12 * 400000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
